### hdl/axis_halfplane_enclosing_box_unit_macros.svh
`ifndef AXIS_HALFPLANE_ENCLOSING_BOX_UNIT_MACROS_SVH
`define AXIS_HALFPLANE_ENCLOSING_BOX_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define AXHP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("axhp check failed");
`define AXHP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("axhp check failed");
`else
`define AXHP_ASSERT_IMP(lbl, ante, cons)
`define AXHP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hdl/axhp_pkg.sv
package axhp_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned NumW     = CoordW + FracBits;
  localparam int unsigned DivSteps = NumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam int unsigned AreaW    = 2 * CoordW;

  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdAdd   = 2'd1;
  localparam logic [1:0] CmdQuery = 2'd2;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatDegen = 2'd2
  } status_e;

  typedef struct packed {
    logic    clear;
    logic    load;
    logic    div_step;
    logic    write;
    logic    scan_init;
    logic    scan_issue;
    logic    diff;
    logic    res_we;
    logic    res_query;
    status_e res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic a_zero;
    logic scan_done;
    logic pipe_idle;
  } dp_stat_t;

  typedef struct packed {
    logic                     vertical;
    logic signed [CoordW-1:0] coef;
    logic signed [CoordW-1:0] term;
    logic signed [CoordW-1:0] line;
  } plane_t;

endpackage

### hdl/axhp_ctrl.sv
`include "axis_halfplane_enclosing_box_unit_macros.svh"

module axhp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         cmd_i,
  input  axhp_pkg::dp_stat_t stat_i,
  output axhp_pkg::dp_cmd_t  dp_cmd_o,
  output logic               busy_o,
  output logic               done_o
);
  import axhp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ADD   = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_WRITE = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_DRAIN = 8'b0010_0000,
    S_DIFF  = 8'b0100_0000,
    S_MUL   = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic               done_q, done_d;

  always_comb begin
    state_d             = state_q;
    div_cnt_d           = div_cnt_q;
    done_d              = 1'b0;
    dp_cmd_o            = '0;
    dp_cmd_o.res_status = StatOk;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (cmd_i)
            CmdClear: begin
              dp_cmd_o.clear  = 1'b1;
              dp_cmd_o.res_we = 1'b1;
              done_d          = 1'b1;
            end
            CmdAdd: begin
              dp_cmd_o.load = 1'b1;
              state_d       = S_ADD;
            end
            CmdQuery: begin
              dp_cmd_o.load      = 1'b1;
              dp_cmd_o.scan_init = 1'b1;
              state_d            = S_SCAN;
            end
            default: begin
              dp_cmd_o.res_we = 1'b1;
              done_d          = 1'b1;
            end
          endcase
        end
      end
      S_ADD: begin
        if (stat_i.full) begin
          dp_cmd_o.res_we     = 1'b1;
          dp_cmd_o.res_status = StatFull;
          done_d              = 1'b1;
          state_d             = S_IDLE;
        end else if (stat_i.a_zero) begin
          dp_cmd_o.res_we     = 1'b1;
          dp_cmd_o.res_status = StatDegen;
          done_d              = 1'b1;
          state_d             = S_IDLE;
        end else begin
          div_cnt_d = '0;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        dp_cmd_o.div_step = 1'b1;
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = S_WRITE;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end
      S_WRITE: begin
        dp_cmd_o.write  = 1'b1;
        dp_cmd_o.res_we = 1'b1;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_DRAIN;
        end else begin
          dp_cmd_o.scan_issue = 1'b1;
        end
      end
      S_DRAIN: begin
        if (stat_i.pipe_idle) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        dp_cmd_o.diff = 1'b1;
        state_d       = S_MUL;
      end
      S_MUL: begin
        dp_cmd_o.res_we    = 1'b1;
        dp_cmd_o.res_query = 1'b1;
        done_d             = 1'b1;
        state_d            = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      div_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
      done_q    <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  `AXHP_ASSERT_NXT(a_clear_reply, start_i && !busy_o && cmd_i == CmdClear, done_q)
  `AXHP_ASSERT_IMP(a_done_idle, done_q, state_q == S_IDLE)
  `AXHP_ASSERT_IMP(a_div_range, state_q == S_DIV, div_cnt_q < DivCntW'(DivSteps))

endmodule

### hdl/axhp_dp.sv
`include "axis_halfplane_enclosing_box_unit_macros.svh"

module axhp_dp #(
  parameter int unsigned MAX_PLANES = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  axhp_pkg::dp_cmd_t                 cmd_i,
  output axhp_pkg::dp_stat_t                stat_o,
  input  logic signed [axhp_pkg::CoordW-1:0] coef_x_i,
  input  logic signed [axhp_pkg::CoordW-1:0] coef_y_i,
  input  logic signed [axhp_pkg::CoordW-1:0] offset_i,
  input  logic signed [axhp_pkg::CoordW-1:0] point_x_i,
  input  logic signed [axhp_pkg::CoordW-1:0] point_y_i,
  output logic [1:0]                        status_o,
  output logic                              box_found_o,
  output logic [axhp_pkg::AreaW-1:0]        box_area_o
);
  import axhp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PLANES + 1);
  localparam int unsigned IdxW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

  plane_t mem [MAX_PLANES];

  // captured request
  logic                     vert_q;
  logic signed [CoordW-1:0] a_q, b_q, px_q, py_q;
  logic signed [CoordW-1:0] a_sel;
  logic        [CoordW-1:0] a_mag, b_mag;

  // divider
  logic [CoordW-1:0] rem_q, den_q;
  logic [NumW-1:0]   dvd_q;
  logic              neg_q;
  logic [CoordW:0]   rem_sh, rem_sub;
  logic              q_bit;
  logic [CoordW-1:0] line_w;

  // table and scan
  logic [CntW-1:0] cnt_q, addr_q;
  plane_t          rd_q;
  logic            v1_q, v2_q;
  logic signed [CoordW-1:0]   s2_term_q, s2_line_q, s2_c_q;
  logic                       s2_vert_q;
  logic signed [AreaW-1:0]    prod_q;
  logic signed [AreaW-1:0]    sum_w;
  logic                       hit, lt, gt;

  // bounds
  logic signed [CoordW-1:0] xlo_q, xhi_q, ylo_q, yhi_q;
  logic signed [CoordW-1:0] xlo_d, xhi_d, ylo_d, yhi_d;
  logic                     fxlo_q, fxhi_q, fylo_q, fyhi_q;
  logic                     fxlo_d, fxhi_d, fylo_d, fyhi_d;
  logic [CoordW-1:0]        w_q, h_q;
  logic                     found_all;

  logic [1:0]       status_q;
  logic             found_q;
  logic [AreaW-1:0] area_q;

  assign a_sel = (coef_x_i == '0) ? coef_y_i : coef_x_i;
  assign a_mag = a_sel[CoordW-1] ? (~a_sel + 1'b1) : a_sel;
  assign b_mag = offset_i[CoordW-1] ? (~offset_i + 1'b1) : offset_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vert_q <= (coef_x_i == '0);
      a_q    <= a_sel;
      b_q    <= offset_i;
      px_q   <= point_x_i;
      py_q   <= point_y_i;
      den_q  <= a_mag;
      rem_q  <= '0;
      dvd_q  <= {b_mag, {FracBits{1'b0}}};
      neg_q  <= (!offset_i[CoordW-1] && offset_i != '0) != a_sel[CoordW-1];
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? rem_sub[CoordW-1:0] : rem_sh[CoordW-1:0];
      dvd_q <= {dvd_q[NumW-2:0], q_bit};
    end
  end

  assign rem_sh  = {rem_q, dvd_q[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign q_bit   = (rem_sh >= {1'b0, den_q});

  always_comb begin
    if (neg_q) begin
      if (dvd_q > {{(NumW-CoordW){1'b0}}, 1'b1, {(CoordW-1){1'b0}}}) begin
        line_w = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
        line_w = ~dvd_q[CoordW-1:0] + 1'b1;
      end
    end else begin
      if (|dvd_q[NumW-1:CoordW-1]) begin
        line_w = {1'b0, {(CoordW-1){1'b1}}};
      end else begin
        line_w = dvd_q[CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem[cnt_q[IdxW-1:0]] <= '{vertical: vert_q, coef: a_q, term: b_q, line: line_w};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      rd_q <= mem[addr_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      addr_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      fxlo_q <= 1'b0;
      fxhi_q <= 1'b0;
      fylo_q <= 1'b0;
      fyhi_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        cnt_q <= '0;
      end else if (cmd_i.write) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.scan_init) begin
        addr_q <= '0;
      end else if (cmd_i.scan_issue) begin
        addr_q <= addr_q + 1'b1;
      end
      v1_q   <= cmd_i.scan_issue;
      v2_q   <= v1_q;
      fxlo_q <= fxlo_d;
      fxhi_q <= fxhi_d;
      fylo_q <= fylo_d;
      fyhi_q <= fyhi_d;
    end
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q    <= rd_q.coef * (rd_q.vertical ? py_q : px_q);
      s2_term_q <= rd_q.term;
      s2_line_q <= rd_q.line;
      s2_vert_q <= rd_q.vertical;
      s2_c_q    <= rd_q.vertical ? py_q : px_q;
    end
  end

  // containment test and bound update
  always_comb begin
    sum_w  = prod_q + {{(AreaW-CoordW-FracBits){s2_term_q[CoordW-1]}}, s2_term_q,
                       {FracBits{1'b0}}};
    hit    = v2_q & sum_w[AreaW-1];
    lt     = (s2_line_q < s2_c_q);
    gt     = (s2_line_q > s2_c_q);
    xlo_d  = xlo_q;
    xhi_d  = xhi_q;
    ylo_d  = ylo_q;
    yhi_d  = yhi_q;
    fxlo_d = fxlo_q;
    fxhi_d = fxhi_q;
    fylo_d = fylo_q;
    fyhi_d = fyhi_q;
    if (cmd_i.scan_init) begin
      fxlo_d = 1'b0;
      fxhi_d = 1'b0;
      fylo_d = 1'b0;
      fyhi_d = 1'b0;
    end else if (hit) begin
      if (s2_vert_q) begin
        if (lt && (!fylo_q || s2_line_q > ylo_q)) begin
          ylo_d  = s2_line_q;
          fylo_d = 1'b1;
        end
        if (gt && (!fyhi_q || s2_line_q < yhi_q)) begin
          yhi_d  = s2_line_q;
          fyhi_d = 1'b1;
        end
      end else begin
        if (lt && (!fxlo_q || s2_line_q > xlo_q)) begin
          xlo_d  = s2_line_q;
          fxlo_d = 1'b1;
        end
        if (gt && (!fxhi_q || s2_line_q < xhi_q)) begin
          xhi_d  = s2_line_q;
          fxhi_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    xlo_q <= xlo_d;
    xhi_q <= xhi_d;
    ylo_q <= ylo_d;
    yhi_q <= yhi_d;
    if (cmd_i.diff) begin
      w_q <= xhi_q - xlo_q;
      h_q <= yhi_q - ylo_q;
    end
  end

  assign found_all = fxlo_q & fxhi_q & fylo_q & fyhi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_we) begin
      status_q <= cmd_i.res_status;
      found_q  <= cmd_i.res_query & found_all;
      area_q   <= (cmd_i.res_query && found_all) ? AreaW'(w_q * h_q) : '0;
    end
  end

  assign stat_o.full      = (cnt_q == CntW'(MAX_PLANES));
  assign stat_o.a_zero    = (a_q == '0);
  assign stat_o.scan_done = (addr_q == cnt_q);
  assign stat_o.pipe_idle = !v1_q && !v2_q;

  assign status_o    = status_q;
  assign box_found_o = found_q;
  assign box_area_o  = area_q;

  `AXHP_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CntW'(MAX_PLANES))
  `AXHP_ASSERT_IMP(a_write_room, cmd_i.write, !stat_o.full)
  `AXHP_ASSERT_NXT(a_pipe_flow, v1_q, v2_q)
  `AXHP_ASSERT_IMP(a_box_order, fxlo_q && fxhi_q, xlo_q < xhi_q)

endmodule

### hdl/axis_halfplane_enclosing_box_unit.sv
// channel   direction  handshake              payload
// request   in         start high, busy low   cmd_i coef_x_i coef_y_i offset_i point_x_i point_y_i
// result    out        done_o, one cycle      status_o box_found_o box_area_o
//
// clear and unused commands reply in the cycle after the request; an add on a full table
// or with a zero coefficient replies from the add check state, any other add after the
// 48 step restoring divider and the table write; a query reads, multiplies and compares
// one plane per cycle, drains the pipe, takes the box width and height, then multiplies the area
// rst_ni clears the fsm, the plane count, the scan address, the bound flags and the pipe valid bits; no memory sweep
// the result receiver cannot stall: done_o is high for one cycle only per reply
module axis_halfplane_enclosing_box_unit #(
  parameter int unsigned MAX_PLANES = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         cmd_i,
  input  logic signed [axhp_pkg::CoordW-1:0] coef_x_i,
  input  logic signed [axhp_pkg::CoordW-1:0] coef_y_i,
  input  logic signed [axhp_pkg::CoordW-1:0] offset_i,
  input  logic signed [axhp_pkg::CoordW-1:0] point_x_i,
  input  logic signed [axhp_pkg::CoordW-1:0] point_y_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic                               box_found_o,
  output logic [axhp_pkg::AreaW-1:0]         box_area_o
);
  import axhp_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  axhp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cmd_i    (cmd_i),
    .stat_i   (dp_stat),
    .dp_cmd_o (dp_cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  axhp_dp #(
    .MAX_PLANES (MAX_PLANES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .coef_x_i    (coef_x_i),
    .coef_y_i    (coef_y_i),
    .offset_i    (offset_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .status_o    (status_o),
    .box_found_o (box_found_o),
    .box_area_o  (box_area_o)
  );

endmodule

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import axhp_pkg::*;

  localparam int unsigned MaxPlanes   = 256;
  localparam int unsigned RandomItems = 1040;
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = 64;
  localparam int          One         = 1 << FracBits;
  localparam logic [1:0]  CmdNone     = 2'd3;
  localparam longint      Int32Max    = 64'sd2147483647;
  localparam longint      Int32Min    = -64'sd2147483648;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    status_e           status;
    logic              found;
    logic [AreaW-1:0]  area;
  } box_reply_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       cmd_i;
  coord_t           coef_x_i;
  coord_t           coef_y_i;
  coord_t           offset_i;
  coord_t           point_x_i;
  coord_t           point_y_i;
  logic             done_o;
  logic [1:0]       status_o;
  logic             box_found_o;
  logic [AreaW-1:0] box_area_o;

  // model of the plane table
  plane_t      plane_tab[MaxPlanes];
  int unsigned plane_cnt;

  box_reply_t  box_reply_q[$];
  box_reply_t  want_reply;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit          idle_on;

  axis_halfplane_enclosing_box_unit #(
    .MAX_PLANES(MaxPlanes)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .coef_x_i   (coef_x_i),
    .coef_y_i   (coef_y_i),
    .offset_i   (offset_i),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .box_found_o(box_found_o),
    .box_area_o (box_area_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic box_reply_t compute_box_reply(input logic [1:0] cmd, input coord_t cx,
                                                   input coord_t cy, input coord_t b,
                                                   input coord_t px, input coord_t py);
    box_reply_t      r;
    longint          a;
    longint          num;
    longint          coord;
    longint          lin;
    longint          xlo;
    longint          xhi;
    longint          ylo;
    longint          yhi;
    bit              vert;
    bit              fxlo;
    bit              fxhi;
    bit              fylo;
    bit              fyhi;
    longint unsigned w;
    longint unsigned h;
    r = '{status: StatOk, found: 1'b0, area: '0};
    xlo = 0;
    xhi = 0;
    ylo = 0;
    yhi = 0;
    fxlo = 1'b0;
    fxhi = 1'b0;
    fylo = 1'b0;
    fyhi = 1'b0;
    case (cmd)
      CmdClear: begin
        plane_cnt = 0;
      end
      CmdAdd: begin
        vert = (cx == 0);
        a = vert ? longint'(cy) : longint'(cx);
        if (plane_cnt >= MaxPlanes) begin
          r.status = StatFull;
        end else if (a == 0) begin
          r.status = StatDegen;
        end else begin
          num = (-longint'(b) * 65536) / a;
          if (num > Int32Max) begin
            num = Int32Max;
          end else if (num < Int32Min) begin
            num = Int32Min;
          end
          plane_tab[plane_cnt] = '{vertical: vert, coef: a[CoordW-1:0], term: b,
                                   line: num[CoordW-1:0]};
          plane_cnt++;
        end
      end
      CmdQuery: begin
        for (int unsigned i = 0; i < plane_cnt; i++) begin
          coord = plane_tab[i].vertical ? longint'(py) : longint'(px);
          lin = longint'($signed(plane_tab[i].line));
          if (longint'($signed(plane_tab[i].coef)) * coord +
              longint'($signed(plane_tab[i].term)) * 65536 < 0) begin
            if (plane_tab[i].vertical) begin
              if (lin < coord && (!fylo || lin > ylo)) begin
                ylo = lin;
                fylo = 1'b1;
              end
              if (lin > coord && (!fyhi || lin < yhi)) begin
                yhi = lin;
                fyhi = 1'b1;
              end
            end else begin
              if (lin < coord && (!fxlo || lin > xlo)) begin
                xlo = lin;
                fxlo = 1'b1;
              end
              if (lin > coord && (!fxhi || lin < xhi)) begin
                xhi = lin;
                fxhi = 1'b1;
              end
            end
          end
        end
        if (fxlo && fxhi && fylo && fyhi) begin
          w = $unsigned(xhi - xlo);
          h = $unsigned(yhi - ylo);
          r.found = 1'b1;
          if (w != 0 && h > 64'hFFFF_FFFF_FFFF_FFFF / w) begin
            r.area = '1;
          end else begin
            r.area = w * h;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // random idle cycles with start low and junk on the payload
  task automatic idle_gap;
    while (idle_on && $urandom_range(99) < 28) begin
      start = 1'b0;
      cmd_i = 2'($urandom);
      coef_x_i = coord_t'($urandom);
      coef_y_i = coord_t'($urandom);
      offset_i = coord_t'($urandom);
      point_x_i = coord_t'($urandom);
      point_y_i = coord_t'($urandom);
      @(negedge clk_i);
    end
  endtask

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic issue_request(input logic [1:0] cmd, input coord_t cx, input coord_t cy,
                               input coord_t b, input coord_t px, input coord_t py);
    idle_gap();
    start = 1'b1;
    cmd_i = cmd;
    coef_x_i = cx;
    coef_y_i = cy;
    offset_i = b;
    point_x_i = px;
    point_y_i = py;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    box_reply_q.push_back(compute_box_reply(cmd, cx, cy, b, px, py));
    @(negedge clk_i);
  endtask

  task automatic wait_drained;
    start = 1'b0;
    while (box_reply_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic coord_t near_coord(input int spread);
    if ($urandom_range(9) == 0) begin
      return coord_t'($urandom);
    end
    return coord_t'(int'($urandom_range(2 * spread)) - spread);
  endfunction

  // plane whose support line lands near the query region, or now and then a zero coefficient add
  task automatic add_random_plane(input int spread);
    coord_t a;
    coord_t ln;
    coord_t b;
    longint prod;
    if ($urandom_range(19) == 0) begin
      issue_request(CmdAdd, '0, '0, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
      return;
    end
    if ($urandom_range(3) == 0) begin
      a = coord_t'($urandom);
    end else begin
      a = coord_t'($urandom_range(1, 4 * One));
      if ($urandom_range(1)) a = -a;
    end
    if (a == 0) a = 1;
    ln = coord_t'(int'($urandom_range(2 * spread)) - spread);
    prod = -((longint'(ln) * longint'(a)) >>> FracBits);
    if (prod > Int32Max) begin
      prod = Int32Max;
    end else if (prod < Int32Min) begin
      prod = Int32Min;
    end
    b = prod[CoordW-1:0];
    if ($urandom_range(1)) begin
      issue_request(CmdAdd, '0, a, b, coord_t'($urandom), coord_t'($urandom));
    end else begin
      issue_request(CmdAdd, a, coord_t'($urandom), b, coord_t'($urandom), coord_t'($urandom));
    end
  endtask

  task automatic test_directed;
    issue_request(CmdClear, '0, '0, '0, '0, '0);
    issue_request(CmdQuery, '0, '0, '0, '0, '0);
    issue_request(CmdAdd, One, coord_t'($urandom), -10 * One, '0, '0);
    issue_request(CmdAdd, -One, coord_t'($urandom), -5 * One, '0, '0);
    issue_request(CmdAdd, '0, One, -7 * One, '0, '0);
    issue_request(CmdQuery, '0, '0, '0, '0, '0);
    issue_request(CmdAdd, '0, -One, -3 * One, '0, '0);
    issue_request(CmdQuery, '0, '0, '0, '0, '0);
    // zero coefficient
    issue_request(CmdAdd, '0, '0, 32'sd123, '0, '0);
    // contained plane with its line exactly on the point
    issue_request(CmdAdd, 32'sd3, '0, -32'sd1, '0, '0);
    issue_request(CmdQuery, '0, '0, '0, 32'sd21845, '0);
    // extreme coefficients and offsets, saturated lines
    issue_request(CmdAdd, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, '0);
    issue_request(CmdAdd, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, '0, '0);
    issue_request(CmdAdd, 32'sd1, '0, 32'sh7FFF_FFFF, '0, '0);
    issue_request(CmdAdd, '0, 32'sh8000_0000, 32'sh8000_0000, '0, '0);
    issue_request(CmdAdd, '0, 32'sd1, 32'sh8000_0000, '0, '0);
    issue_request(CmdQuery, '0, '0, '0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    issue_request(CmdQuery, '0, '0, '0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    issue_request(CmdQuery, '0, '0, '0, One, One);
    issue_request(CmdNone, '1, '1, '1, '1, '1);
    issue_request(CmdQuery, '0, '0, '0, '0, '0);
    issue_request(CmdClear, '1, '1, '1, '1, '1);
    issue_request(CmdQuery, '0, '0, '0, '0, '0);
  endtask

  task automatic test_table_full;
    issue_request(CmdClear, '0, '0, '0, '0, '0);
    while (plane_cnt < MaxPlanes) add_random_plane(One);
    issue_request(CmdAdd, One, '0, -One, '0, '0);
    // full wins over a zero coefficient
    issue_request(CmdAdd, '0, '0, 32'sd5, '0, '0);
    repeat (3) issue_request(CmdQuery, '0, '0, '0, near_coord(One), near_coord(One));
    issue_request(CmdClear, '0, '0, '0, '0, '0);
    issue_request(CmdQuery, '0, '0, '0, '0, '0);
  endtask

  task automatic test_random_mix;
    int unsigned sent;
    int unsigned rounds;
    int unsigned n;
    int          spread;
    sent = 0;
    rounds = 0;
    while (sent < RandomItems) begin
      // long stretch with no idle cycles
      idle_on = !(rounds >= 15 && rounds < 25);
      rounds++;
      case ($urandom_range(2))
        0: spread = 1 << 8;
        1: spread = 1 << 16;
        default: spread = 1 << 24;
      endcase
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          issue_request(2'($urandom_range(3)), coord_t'($urandom), coord_t'($urandom),
                        coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        end
        sent += n;
      end else begin
        if ($urandom_range(4) != 0) begin
          issue_request(CmdClear, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                        coord_t'($urandom), coord_t'($urandom));
          sent++;
        end
        n = $urandom_range(4, 24);
        if ($urandom_range(39) == 0) n = $urandom_range(200, 270);
        repeat (n) add_random_plane(spread);
        sent += n;
        n = $urandom_range(1, 6);
        repeat (n) begin
          issue_request(CmdQuery, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                        near_coord(spread), near_coord(spread));
        end
        sent += n;
      end
      if ($urandom_range(14) == 0) wait_drained();
    end
    idle_on = 1'b1;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (box_reply_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected result: status %0d found %0b area %h",
                   status_o, box_found_o, box_area_o);
        end
      end else begin
        want_reply = box_reply_q.pop_front();
        if (status_o !== want_reply.status || box_found_o !== want_reply.found ||
            box_area_o !== want_reply.area) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: expected status %0d found %0b area %h, got %0d %0b %h",
                     want_reply.status, want_reply.found, want_reply.area,
                     status_o, box_found_o, box_area_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("axis_halfplane_enclosing_box_unit verification failed");
      $finish;
    end
  end

  initial begin
    mismatch_cnt = 0;
    cycle_cnt = 0;
    plane_cnt = 0;
    idle_on = 1'b1;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    coef_x_i = '0;
    coef_y_i = '0;
    offset_i = '0;
    point_x_i = '0;
    point_y_i = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    wait_drained();
    test_table_full();
    wait_drained();
    test_random_mix();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && box_reply_q.size() == 0) begin
      $display("axis_halfplane_enclosing_box_unit verification clean");
    end else begin
      $display("axis_halfplane_enclosing_box_unit verification failed");
    end
    $finish;
  end

endmodule
